[rtl/core/ne_entry_table_parser_assert.svh]
// Assertion macros used by the checker file of the entry table parser.
`ifndef NE_ENTRY_TABLE_PARSER_ASSERT_SVH
`define NE_ENTRY_TABLE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NETP_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("entry table parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NETP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("entry table parser assertion failed");

`endif

[rtl/core/netp_pkg.sv]
package netp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;

  localparam logic [7:0] SEG_SKIP    = 8'h00;
  localparam logic [7:0] SEG_MOVABLE = 8'hFF;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_SEG   = 3'd1;
  localparam logic [2:0] PH_FLAG  = 3'd2;
  localparam logic [2:0] PH_SKIP1 = 3'd3;
  localparam logic [2:0] PH_SKIP2 = 3'd4;
  localparam logic [2:0] PH_SKIP3 = 3'd5;
  localparam logic [2:0] PH_OFFLO = 3'd6;
  localparam logic [2:0] PH_OFFHI = 3'd7;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] ordinal;
    logic [15:0] offset;
    logic        recorded;
    logic [5:0]  export_count;
  } res_t;

endpackage

[rtl/core/ne_entry_table_parser.sv]
// Entry table parser for a segmented executable.
// The input channel carries one raw table byte per transfer, with a start flag
// that restarts the parser and marks the byte as the count byte of a new table.
// The output channel carries one result per completed entry (ordinal, offset,
// recorded flag, export count) and one end result when a zero count byte ends
// the table. Bytes after the end produce nothing until a start flag arrives.
// One byte is accepted every cycle while in_stall is low. The phase machine
// updates on each transfer, and its result is registered at the same clock edge.
// Results sit in an output register backed by one skid register, so a byte is
// still accepted while one result waits under stall. in_stall rises only when
// both are full and falls the cycle after the receiver takes a result.
// After reset the parser waits for a count byte, both result registers are
// empty, and the first byte is treated as a count byte even without a start.
module ne_entry_table_parser
  import netp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_table_byte,
  input  logic        in_start_table,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [15:0] out_ordinal,
  output logic [15:0] out_entry_offset,
  output logic        out_recorded,
  output logic [5:0]  out_export_count
);

  localparam logic [15:0] EntryLimit = 16'(TABLE_ENTRIES);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        movable_r, movable_nxt;
  logic [15:0] ord_r, ord_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [7:0]  off_lo_r, off_lo_nxt;
  logic        done_r, done_nxt;

  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r, out_res_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  res_t        skid_res_r, skid_res_nxt;

  logic        accept;
  logic        produce;
  res_t        res;
  logic [7:0]  left_dec;
  logic        rec;
  logic [5:0]  cnt;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    movable_nxt = movable_r;
    ord_nxt     = ord_r;
    count_nxt   = count_r;
    off_lo_nxt  = off_lo_r;
    done_nxt    = done_r;
    produce     = 1'b0;
    res         = '0;
    rec         = 1'b0;
    cnt         = '0;
    if (in_start_table) begin
      phase_nxt   = PH_COUNT;
      left_nxt    = '0;
      movable_nxt = 1'b0;
      ord_nxt     = '0;
      count_nxt   = '0;
      off_lo_nxt  = '0;
      done_nxt    = 1'b0;
    end
    if (!done_nxt) begin
      case (phase_nxt)
        PH_COUNT: begin
          if (in_table_byte == 8'd0) begin
            done_nxt         = 1'b1;
            produce          = 1'b1;
            res.kind         = KIND_END;
            res.ordinal      = ord_nxt;
            res.export_count = count_nxt;
          end else begin
            left_nxt  = in_table_byte;
            phase_nxt = PH_SEG;
          end
        end
        PH_SEG: begin
          if (in_table_byte == SEG_SKIP) begin
            ord_nxt   = ord_nxt + 16'(left_nxt);
            left_nxt  = '0;
            phase_nxt = PH_COUNT;
          end else begin
            movable_nxt = (in_table_byte == SEG_MOVABLE);
            phase_nxt   = PH_FLAG;
          end
        end
        PH_FLAG:  phase_nxt = movable_nxt ? PH_SKIP1 : PH_OFFLO;
        PH_SKIP1: phase_nxt = PH_SKIP2;
        PH_SKIP2: phase_nxt = PH_SKIP3;
        PH_SKIP3: phase_nxt = PH_OFFLO;
        PH_OFFLO: begin
          off_lo_nxt = in_table_byte;
          phase_nxt  = PH_OFFHI;
        end
        PH_OFFHI: begin
          rec = (ord_r < EntryLimit);
          cnt = (ord_r < 16'(COUNT_MAX)) ? (ord_r[5:0] + 6'd1) : COUNT_MAX;
          if (rec && (cnt > count_r)) begin
            count_nxt = cnt;
          end
          ord_nxt          = ord_r + 16'd1;
          left_nxt         = left_dec;
          phase_nxt        = (left_dec == 8'd0) ? PH_COUNT : PH_FLAG;
          produce          = 1'b1;
          res.kind         = KIND_ENTRY;
          res.ordinal      = ord_r;
          res.offset       = {in_table_byte, off_lo_r};
          res.recorded     = rec;
          res.export_count = count_nxt;
        end
        default: phase_nxt = PH_COUNT;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (out_valid_r && out_stall) begin
      if (accept && produce) begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = res;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_res_nxt    = skid_res_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = accept && produce;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      left_r       <= '0;
      movable_r    <= 1'b0;
      ord_r        <= '0;
      count_r      <= '0;
      off_lo_r     <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        left_r    <= left_nxt;
        movable_r <= movable_nxt;
        ord_r     <= ord_nxt;
        count_r   <= count_nxt;
        off_lo_r  <= off_lo_nxt;
        done_r    <= done_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_ordinal      = out_res_r.ordinal;
  assign out_entry_offset = out_res_r.offset;
  assign out_recorded     = out_res_r.recorded;
  assign out_export_count = out_res_r.export_count;

endmodule

[rtl/core/netp_checker.sv]
`include "ne_entry_table_parser_assert.svh"

module netp_checker
  import netp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_table_byte,
  input logic        in_start_table,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [15:0] out_ordinal,
  input logic [15:0] out_entry_offset,
  input logic        out_recorded,
  input logic [5:0]  out_export_count
);

  localparam logic [15:0] EntryLimit = 16'(TABLE_ENTRIES);

  logic        unused_inputs;
  logic        out_wait;
  logic        rec_shown;
  logic        end_shown;
  logic        end_clean;
  logic        low_rec;
  logic [39:0] out_fields;

  assign unused_inputs = in_valid ^ in_stall ^ (^in_table_byte) ^ in_start_table;
  assign out_wait      = out_valid && out_stall;
  assign rec_shown     = out_valid && out_recorded;
  assign end_shown     = out_valid && (out_result_kind == KIND_END);
  assign end_clean     = (out_entry_offset == 16'd0) && !out_recorded;
  assign low_rec       = rec_shown && (out_ordinal < 16'(COUNT_MAX));
  assign out_fields    = {out_result_kind, out_ordinal, out_entry_offset, out_recorded,
                          out_export_count};

  `NETP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_fields))
  `NETP_ASSERT_SAME(a_rec_in_range, clk, rst_n, rec_shown, out_ordinal < EntryLimit)
  `NETP_ASSERT_SAME(a_end_fields, clk, rst_n, end_shown, end_clean)
  `NETP_ASSERT_SAME(a_count_covers, clk, rst_n, low_rec, out_export_count > out_ordinal[5:0])

endmodule

bind ne_entry_table_parser netp_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_netp_checker (.*);

[test/ne_entry_table_parser_checker.sv]
`timescale 1ns / 1ps

module ne_entry_table_parser_checker
  import netp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_table_byte,
  input  logic        in_start_table,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [15:0] out_ordinal,
  input  logic [15:0] out_entry_offset,
  input  logic        out_recorded,
  input  logic [5:0]  out_export_count,
  output int          error_count,
  output int          results_due
);

  logic [2:0]  parse_phase;
  logic [7:0]  entries_left;
  logic        movable_bundle;
  logic [15:0] ordinal_next;
  logic [5:0]  export_hwm;
  logic [7:0]  offset_lo;
  logic        table_ended;

  res_t expected_results[$];
  int   mismatches = 0;

  task clear_parser();
    parse_phase    = PH_COUNT;
    entries_left   = 8'd0;
    movable_bundle = 1'b0;
    ordinal_next   = 16'd0;
    export_hwm     = 6'd0;
    offset_lo      = 8'd0;
    table_ended    = 1'b0;
  endtask

  task parse_table_byte(input logic [7:0] value, input logic restart);
    res_t        r;
    logic [15:0] ord;
    logic [16:0] hwm;
    if (restart) begin
      clear_parser();
    end else if (table_ended) begin
      return;
    end
    case (parse_phase)
      PH_COUNT: begin
        if (value == 8'd0) begin
          table_ended = 1'b1;
          r = '{KIND_END, ordinal_next, 16'd0, 1'b0, export_hwm};
          expected_results.push_back(r);
        end else begin
          entries_left = value;
          parse_phase  = PH_SEG;
        end
      end
      PH_SEG: begin
        if (value == SEG_SKIP) begin
          ordinal_next = ordinal_next + {8'd0, entries_left};
          entries_left = 8'd0;
          parse_phase  = PH_COUNT;
        end else begin
          movable_bundle = (value == SEG_MOVABLE);
          parse_phase    = PH_FLAG;
        end
      end
      PH_FLAG:  parse_phase = movable_bundle ? PH_SKIP1 : PH_OFFLO;
      PH_SKIP1: parse_phase = PH_SKIP2;
      PH_SKIP2: parse_phase = PH_SKIP3;
      PH_SKIP3: parse_phase = PH_OFFLO;
      PH_OFFLO: begin
        offset_lo   = value;
        parse_phase = PH_OFFHI;
      end
      PH_OFFHI: begin
        ord = ordinal_next;
        if (ord < TABLE_ENTRIES_DEF) begin
          hwm = {1'b0, ord} + 17'd1;
          if (hwm > COUNT_MAX) begin
            hwm = {11'd0, COUNT_MAX};
          end
          if (hwm > export_hwm) begin
            export_hwm = hwm[5:0];
          end
        end
        ordinal_next = ordinal_next + 16'd1;
        entries_left = entries_left - 8'd1;
        parse_phase  = (entries_left == 8'd0) ? PH_COUNT : PH_FLAG;
        r = '{KIND_ENTRY, ord, {value, offset_lo}, (ord < TABLE_ENTRIES_DEF), export_hwm};
        expected_results.push_back(r);
      end
      default: parse_phase = PH_COUNT;
    endcase
  endtask

  task check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result with none expected: kind %0d ord %0d off %h rec %0d cnt %0d",
                 $realtime, out_result_kind, out_ordinal, out_entry_offset, out_recorded,
                 out_export_count);
      end
      return;
    end
    want = expected_results.pop_front();
    if (out_result_kind !== want.kind || out_ordinal !== want.ordinal ||
        out_entry_offset !== want.offset || out_recorded !== want.recorded ||
        out_export_count !== want.export_count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: expected kind %0d ord %0d off %h rec %0d cnt %0d", $realtime,
                 want.kind, want.ordinal, want.offset, want.recorded, want.export_count);
        $display("%0t: actual   kind %0d ord %0d off %h rec %0d cnt %0d", $realtime,
                 out_result_kind, out_ordinal, out_entry_offset, out_recorded,
                 out_export_count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (in_valid && !in_stall) begin
        parse_table_byte(in_table_byte, in_start_table);
      end
    end
    error_count <= mismatches;
    results_due <= expected_results.size();
  end

endmodule

[test/tb_ne_entry_table_parser.sv]
`timescale 1ns / 1ps

module tb_ne_entry_table_parser;
  import netp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_BYTES = 60;

  typedef struct packed {
    logic       start;
    logic [7:0] value;
  } table_byte_t;

  typedef enum int {BUNDLE_SKIP, BUNDLE_FIXED, BUNDLE_MOVABLE} bundle_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_table_byte = 8'd0;
  logic        in_start_table = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [15:0] out_ordinal;
  logic [15:0] out_entry_offset;
  logic        out_recorded;
  logic [5:0]  out_export_count;

  int error_count;
  int results_due;
  int idle_cycles;
  bit steady_sender;
  bit sender_done = 1'b0;

  table_byte_t byte_stream[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ne_entry_table_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_table_byte    (in_table_byte),
    .in_start_table   (in_start_table),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_ordinal      (out_ordinal),
    .out_entry_offset (out_entry_offset),
    .out_recorded     (out_recorded),
    .out_export_count (out_export_count)
  );

  ne_entry_table_parser_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_table_byte    (in_table_byte),
    .in_start_table   (in_start_table),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_ordinal      (out_ordinal),
    .out_entry_offset (out_entry_offset),
    .out_recorded     (out_recorded),
    .out_export_count (out_export_count),
    .error_count      (error_count),
    .results_due      (results_due)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  function automatic void add_byte(input logic [7:0] value, input logic start);
    table_byte_t t;
    t.value = value;
    t.start = start;
    byte_stream.push_back(t);
  endfunction

  function automatic void add_bundle(input bundle_kind_t kind, input logic [7:0] count,
                                     input logic start);
    add_byte(count, start);
    case (kind)
      BUNDLE_SKIP: add_byte(SEG_SKIP, 1'b0);
      BUNDLE_FIXED: begin
        add_byte(8'($urandom_range(1, 254)), 1'b0);
        repeat (count * 3) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      BUNDLE_MOVABLE: begin
        add_byte(SEG_MOVABLE, 1'b0);
        repeat (count * 6) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input table_byte_t t);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_table_byte  <= t.value;
    in_start_table <= t.start;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // At two rounds the receiver holds off until the block stalls its input or the sender is done,
  // and then for a long stretch more.
  initial begin
    int rounds;
    int free_len;
    int hold_len;
    rounds = 0;
    @(negedge clk);
    forever begin
      free_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
      out_stall <= 1'b0;
      repeat (free_len) @(negedge clk);
      rounds++;
      if (rounds == 30 || rounds == 90) begin
        out_stall <= 1'b1;
        while (!in_stall && !sender_done) @(negedge clk);
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        hold_len = pick_gap();
        if (hold_len > 0) begin
          out_stall <= 1'b1;
          repeat (hold_len) @(negedge clk);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int           random_base;
    int           nbundles;
    int           r;
    logic         first;
    bundle_kind_t kind;
    logic [7:0]   count;

    // The first table follows reset without a start flag.
    add_byte(8'd1, 1'b0);
    add_byte(8'h05, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'd1, 1'b0);
    add_byte(SEG_MOVABLE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(SEG_SKIP, 1'b0);
    add_byte(8'd1, 1'b0);
    add_byte(8'h7E, 1'b0);
    add_byte(8'h81, 1'b0);
    add_byte(8'h34, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(8'd0, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(8'd0, 1'b1);
    add_byte(8'd1, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'd0, 1'b1);

    // Skip bundles bring the ordinal to its top value so the next entries wrap.
    add_bundle(BUNDLE_SKIP, 8'd255, 1'b1);
    repeat (256) add_bundle(BUNDLE_SKIP, 8'd255, 1'b0);
    add_bundle(BUNDLE_FIXED, 8'd3, 1'b0);
    add_byte(8'd0, 1'b0);

    random_base = byte_stream.size();
    while (byte_stream.size() < random_base + RANDOM_BYTES) begin
      first    = ($urandom_range(0, 9) != 0);
      nbundles = $urandom_range(0, 5);
      repeat (nbundles) begin
        r = $urandom_range(0, 19);
        kind = (r < 4) ? BUNDLE_SKIP : (r < 13) ? BUNDLE_FIXED : BUNDLE_MOVABLE;
        if ($urandom_range(0, 9) < 8) begin
          count = 8'($urandom_range(1, 3));
        end else if (kind == BUNDLE_SKIP) begin
          count = 8'($urandom_range(1, 255));
        end else begin
          count = 8'($urandom_range(4, 40));
        end
        add_bundle(kind, count, first);
        first = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        add_byte(8'd0, first);
      end else begin
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    steady_sender = 1'b0;
    foreach (byte_stream[i]) begin
      if (i % 64 == 0) begin
        steady_sender = ($urandom_range(0, 3) == 0);
      end
      send_byte(byte_stream[i]);
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;

    while (results_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
